>>> rtl/core/rbv_pkg.sv
// Shared types, constants and register codes of the resonant bell voice.
package rbv_pkg;

  localparam int unsigned FracBits  = 24;
  localparam int unsigned CoeffW    = 24;
  localparam int unsigned DecayW    = 25;
  localparam int unsigned VelocityW = 25;
  localparam int unsigned SampleW   = 16;
  localparam int unsigned AccW      = 32;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 25;

  localparam logic [CoeffW-1:0] FreqReset    = 24'd5975000;
  localparam logic [CoeffW-1:0] DampingReset = 24'd1817531;
  localparam logic [DecayW-1:0] DecayReset   = 25'd16771783;

  localparam logic [CfgIdxW-1:0] CfgFreq    = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgDamping = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgDecay   = 2'd2;

  // Operand pair routed into the shared multiplier.
  typedef enum logic [2:0] {
    MUL_FREQ_BAND,
    MUL_DAMP_BAND,
    MUL_FREQ_HIGH,
    MUL_BAND_ENV,
    MUL_ENV_DECAY
  } mul_sel_e;

  typedef struct packed {
    logic     load_item;
    logic     mul_en;
    mul_sel_e mul_sel;
    logic     ld_low;
    logic     ld_high;
    logic     ld_band;
    logic     ld_shaped;
    logic     ld_env;
    logic     ld_out;
  } cmd_t;

endpackage

>>> rtl/core/rbv_ctrl.sv
// Sequencer that steps one sample through the shared multiplier datapath.
module rbv_ctrl (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        out_ready_i,
  output logic        out_valid_o,
  output rbv_pkg::cmd_t cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL1,
    S_MUL2,
    S_HIGH,
    S_MUL3,
    S_BAND,
    S_MUL4,
    S_MUL5,
    S_DONE
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o           = '0;
    cmd_o.mul_sel   = rbv_pkg::MUL_FREQ_BAND;
    unique case (state_q)
      S_IDLE: cmd_o.load_item = in_valid_i;
      S_MUL1: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = rbv_pkg::MUL_FREQ_BAND;
      end
      S_MUL2: begin
        cmd_o.ld_low  = 1'b1;
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = rbv_pkg::MUL_DAMP_BAND;
      end
      S_HIGH: cmd_o.ld_high = 1'b1;
      S_MUL3: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = rbv_pkg::MUL_FREQ_HIGH;
      end
      S_BAND: cmd_o.ld_band = 1'b1;
      S_MUL4: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = rbv_pkg::MUL_BAND_ENV;
      end
      S_MUL5: begin
        cmd_o.ld_shaped = 1'b1;
        cmd_o.mul_en    = 1'b1;
        cmd_o.mul_sel   = rbv_pkg::MUL_ENV_DECAY;
      end
      S_DONE: begin
        // The product stays in place until the output register frees up.
        cmd_o.ld_env = out_free;
        cmd_o.ld_out = out_free;
      end
      default: cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: if (in_valid_i) state_q <= S_MUL1;
        S_MUL1: state_q <= S_MUL2;
        S_MUL2: state_q <= S_HIGH;
        S_HIGH: state_q <= S_MUL3;
        S_MUL3: state_q <= S_BAND;
        S_BAND: state_q <= S_MUL4;
        S_MUL4: state_q <= S_MUL5;
        S_MUL5: state_q <= S_DONE;
        S_DONE: if (out_free) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
      if (cmd_o.ld_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.ld_out |-> (!out_valid_q || out_ready_i))
    else $error("result written over one still waiting");

  a_one_state_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.ld_low, cmd_o.ld_high, cmd_o.ld_band, cmd_o.ld_env}))
    else $error("two filter state registers written in one step");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == S_MUL1 && !in_ready_o))
    else $error("transfer did not start the sequence");

  a_out_after_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.ld_out |=> (out_valid_o && state_q == S_IDLE))
    else $error("result not presented after the last step");

endmodule

>>> rtl/core/rbv_datapath.sv
// Filter state, coefficient registers and the shared multiplier of the voice.
module rbv_datapath #(
  parameter int unsigned FRAC_BITS = rbv_pkg::FracBits
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [rbv_pkg::CfgIdxW-1:0]         cfg_index_i,
  input  logic [rbv_pkg::CfgDataW-1:0]        cfg_data_i,
  input  logic                                strike_i,
  input  logic [rbv_pkg::VelocityW-1:0]       velocity_i,
  input  rbv_pkg::cmd_t                       cmd_i,
  output logic signed [rbv_pkg::SampleW-1:0]  sample_o
);

  localparam int unsigned AccW  = rbv_pkg::AccW;
  localparam int unsigned EnvW  = FRAC_BITS + 1;
  localparam int unsigned UW    = (EnvW > rbv_pkg::DecayW) ? EnvW : rbv_pkg::DecayW;
  localparam int unsigned AW    = AccW + 1;
  localparam int unsigned BW    = UW + 1;
  localparam int unsigned PW    = AW + BW;
  localparam int unsigned OutSh = FRAC_BITS - 14;
  localparam logic [UW-1:0] OneU = UW'(1) << FRAC_BITS;

  logic [rbv_pkg::CoeffW-1:0] freq_q, damp_q;
  logic [rbv_pkg::DecayW-1:0] decay_q;

  logic [AccW-1:0]        low_acc_q, band_acc_q, high_q, imp_q;
  logic signed [AccW-1:0] shaped_q;
  logic [EnvW-1:0]        env_q;
  logic signed [PW-1:0]   prod_q;
  logic signed [rbv_pkg::SampleW-1:0] sample_q;

  logic signed [AW-1:0] mul_a;
  logic signed [BW-1:0] mul_b;
  logic [AccW-1:0]      fm;
  logic [UW-1:0]        vel_u, vel_c, decay_u, decay_c;
  logic [UW+1:0]        imp_wide;
  logic [AccW-1:0]      low_d, high_d, band_d;
  logic signed [AccW-1:0] scaled;
  logic signed [rbv_pkg::SampleW-1:0] sample_d;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      freq_q  <= rbv_pkg::FreqReset;
      damp_q  <= rbv_pkg::DampingReset;
      decay_q <= rbv_pkg::DecayReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        rbv_pkg::CfgFreq:    freq_q  <= cfg_data_i[rbv_pkg::CoeffW-1:0];
        rbv_pkg::CfgDamping: damp_q  <= cfg_data_i[rbv_pkg::CoeffW-1:0];
        rbv_pkg::CfgDecay:   decay_q <= cfg_data_i[rbv_pkg::DecayW-1:0];
        default: ;
      endcase
    end
  end

  // Strike strength is clamped to unity, then scaled by three halves.
  assign vel_u    = UW'(velocity_i);
  assign vel_c    = (vel_u > OneU) ? OneU : vel_u;
  assign imp_wide = ({2'b00, vel_c} + {1'b0, vel_c, 1'b0}) >> 1;
  assign decay_u  = UW'(decay_q);
  assign decay_c  = (decay_u > OneU) ? OneU : decay_u;

  always_comb begin
    mul_a = {band_acc_q[AccW-1], band_acc_q};
    mul_b = BW'(freq_q);
    unique case (cmd_i.mul_sel)
      rbv_pkg::MUL_FREQ_BAND: begin
        mul_a = {band_acc_q[AccW-1], band_acc_q};
        mul_b = BW'(freq_q);
      end
      rbv_pkg::MUL_DAMP_BAND: begin
        mul_a = {band_acc_q[AccW-1], band_acc_q};
        mul_b = BW'(damp_q);
      end
      rbv_pkg::MUL_FREQ_HIGH: begin
        mul_a = {high_q[AccW-1], high_q};
        mul_b = BW'(freq_q);
      end
      rbv_pkg::MUL_BAND_ENV: begin
        mul_a = {band_acc_q[AccW-1], band_acc_q};
        mul_b = BW'(env_q);
      end
      rbv_pkg::MUL_ENV_DECAY: begin
        mul_a = AW'(env_q);
        mul_b = {1'b0, decay_c};
      end
      default: ;
    endcase
  end

  // An arithmetic shift by the fraction width floors; the low word wraps.
  assign fm     = prod_q[FRAC_BITS +: AccW];
  assign low_d  = low_acc_q + fm;
  assign high_d = imp_q - low_acc_q - fm;
  assign band_d = band_acc_q + fm;

  assign scaled = shaped_q >>> OutSh;
  always_comb begin
    if (scaled > 32'sd32767) begin
      sample_d = 16'sh7fff;
    end else if (scaled < -32'sd32768) begin
      sample_d = 16'sh8000;
    end else begin
      sample_d = scaled[rbv_pkg::SampleW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_acc_q  <= '0;
      band_acc_q <= '0;
      env_q      <= '0;
    end else begin
      if (cmd_i.load_item && strike_i) env_q <= OneU[EnvW-1:0];
      if (cmd_i.ld_env)                env_q <= fm[EnvW-1:0];
      if (cmd_i.ld_low)                low_acc_q <= low_d;
      if (cmd_i.ld_band)               band_acc_q <= band_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) imp_q <= strike_i ? AccW'(imp_wide) : '0;
    if (cmd_i.mul_en)    prod_q <= mul_a * mul_b;
    if (cmd_i.ld_high)   high_q <= high_d;
    if (cmd_i.ld_shaped) shaped_q <= signed'(fm);
    if (cmd_i.ld_out)    sample_q <= sample_d;
  end

  assign sample_o = sample_q;

endmodule

>>> rtl/core/resonant_bell_voice_top.sv
// Struck resonator voice: a state-variable filter excited by strikes.
//
// Input channel (in_valid_i / in_ready_o) carries one sample tick per
// transfer, with strike_i and velocity_i. A strike restarts the envelope and
// injects an impulse of three halves of the clamped velocity. Output channel
// (out_valid_o / out_ready_i) returns one saturated 16-bit sample per tick.
// An item passes the accepting state and eight sequencer steps, set by the
// one shared multiplier that forms the five chained products in turn, each
// registered before use. The result becomes valid as the sequencer returns
// to idle, so the next input can be taken in that same cycle.
// A new input is accepted while the previous result still waits; if the
// receiver stalls, the sequence holds in its last step until the output
// register is free. Reset clears the filter state and envelope and loads the
// default coefficients. Coefficients are written through cfg_we_i,
// cfg_index_i and cfg_data_i; the user must do so only while no tick is in
// progress (not enforced by the block); indexes beyond the list are ignored.
module resonant_bell_voice_top #(
  parameter int unsigned FRAC_BITS = rbv_pkg::FracBits
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [rbv_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [rbv_pkg::CfgDataW-1:0]       cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic                               strike_i,
  input  logic [rbv_pkg::VelocityW-1:0]      velocity_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [rbv_pkg::SampleW-1:0] sample_o
);

  rbv_pkg::cmd_t cmd;

  rbv_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .cmd_o       (cmd)
  );

  rbv_datapath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .strike_i    (strike_i),
    .velocity_i  (velocity_i),
    .cmd_i       (cmd),
    .sample_o    (sample_o)
  );

endmodule
